FILE: hdl/bsri_pkg.sv
// Shared types and constants for the bidi script-run intersect block.
package bsri_pkg;

	localparam int unsigned MAX_RESULTS = 16;
	localparam int unsigned KW = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_LOAD  = 2'd1,
		ACT_RUN   = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] run_offset;
		logic [31:0] run_length;
		logic [6:0]  run_level;
		logic [31:0] run_script;
	} in_item_t;

	typedef struct packed {
		logic [31:0] piece_offset;
		logic [31:0] piece_length;
		logic [31:0] piece_script;
		logic [6:0]  piece_level;
		logic        last_piece;
		logic        table_overflow;
	} out_piece_t;

	typedef struct packed {
		logic        tbl_wr;
		logic        set_ovf;
		logic        run_cap;
		logic        scan_init;
		logic        rd_en;
		logic        s2_en;
		logic        s2_take;
		logic        pend_load;
		logic        pend_out;
		logic        pass_out;
		logic        out_last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic s2_nonempty;
		logic pend_full;
		logic out_free;
		logic any_hit;
	} dp_status_t;

endpackage

FILE: hdl/bsri_ctrl.sv
// Controller state machine: table bookkeeping, scan sequencing and piece hand-off.
module bsri_ctrl import bsri_pkg::*; #(
	parameter int unsigned MAX_SCRIPT_RUNS = 16,
	localparam int unsigned AW = (MAX_SCRIPT_RUNS > 1) ? $clog2(MAX_SCRIPT_RUNS) : 1,
	localparam int unsigned CW = $clog2(MAX_SCRIPT_RUNS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    action,
	input  logic          rtl,
	input  dp_status_t    sts,
	output ctrl_cmd_t     cmd,
	output logic [AW-1:0] wr_addr,
	output logic [AW-1:0] rd_addr
);

	state_t          state_q, state_d;
	logic [CW-1:0]   count_q, count_d;
	logic [CW-1:0]   n_q, n_d;
	logic [KW-1:0]   kcnt_q, kcnt_d;
	logic            vld_s1, vld_s1_d;
	logic            vld_s2, vld_s2_d;
	logic            rtl_q, rtl_d;
	logic            v0;
	logic            adv;
	logic [CW-1:0]   rev_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			n_q     <= '0;
			kcnt_q  <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			rtl_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			n_q     <= n_d;
			kcnt_q  <= kcnt_d;
			vld_s1  <= vld_s1_d;
			vld_s2  <= vld_s2_d;
			rtl_q   <= rtl_d;
		end
	end

	assign v0      = (n_q < count_q);
	assign rev_idx = count_q - CW'(1) - n_q;
	assign rd_addr = rtl_q ? rev_idx[AW-1:0] : n_q[AW-1:0];
	assign wr_addr = count_q[AW-1:0];
	assign adv     = !vld_s2 || !sts.s2_nonempty || !sts.pend_full || sts.out_free;

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		n_d      = n_q;
		kcnt_d   = kcnt_q;
		vld_s1_d = vld_s1;
		vld_s2_d = vld_s2;
		rtl_d    = rtl_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					case (action)
						ACT_CLEAR: begin
							count_d = '0;
						end
						ACT_LOAD: begin
							if (count_q < CW'(MAX_SCRIPT_RUNS)) begin
								cmd.tbl_wr = 1'b1;
								count_d    = count_q + CW'(1);
							end else begin
								cmd.set_ovf = 1'b1;
							end
						end
						ACT_RUN: begin
							cmd.run_cap   = 1'b1;
							cmd.scan_init = 1'b1;
							n_d      = '0;
							kcnt_d   = '0;
							vld_s1_d = 1'b0;
							vld_s2_d = 1'b0;
							rtl_d    = rtl;
							state_d  = ST_SCAN;
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (adv) begin
					cmd.rd_en = v0;
					cmd.s2_en = 1'b1;
					n_d       = v0 ? n_q + CW'(1) : n_q;
					vld_s1_d  = v0;
					vld_s2_d  = vld_s1;
					if (vld_s2) begin
						cmd.s2_take = 1'b1;
						if (sts.s2_nonempty) begin
							cmd.pend_out  = sts.pend_full;
							cmd.pend_load = 1'b1;
							kcnt_d        = kcnt_q + KW'(1);
							if (kcnt_q == KW'(MAX_RESULTS - 1)) begin
								vld_s1_d = 1'b0;
								vld_s2_d = 1'b0;
								state_d  = ST_FINISH;
							end
						end
					end
				end
				if (!v0 && !vld_s1 && !vld_s2) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (sts.pend_full) begin
					if (sts.out_free) begin
						cmd.pend_out = 1'b1;
						cmd.out_last = 1'b1;
						state_d      = ST_IDLE;
					end
				end else if (!sts.any_hit) begin
					if (sts.out_free) begin
						cmd.pass_out = 1'b1;
						state_d      = ST_IDLE;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_kcnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		kcnt_q <= KW'(MAX_RESULTS))
		else $error("piece count exceeds the result limit");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_SCRIPT_RUNS))
		else $error("table count exceeds table depth");

	a_out_no_replace: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.pend_out && !cmd.pend_load) |-> (state_q == ST_FINISH))
		else $error("pending piece sent during scan without a newer piece");

	a_scan_empty_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && $past(state_q) == ST_IDLE) |-> (!vld_s1 && !vld_s2))
		else $error("scan pipeline not empty at scan start");

endmodule

FILE: hdl/bsri_dp.sv
// Datapath: script table memory, clip pipeline, pending piece and output register.
module bsri_dp import bsri_pkg::*; #(
	parameter int unsigned MAX_SCRIPT_RUNS = 16,
	localparam int unsigned AW = (MAX_SCRIPT_RUNS > 1) ? $clog2(MAX_SCRIPT_RUNS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  in_item_t      in_item,
	input  ctrl_cmd_t     cmd,
	input  logic [AW-1:0] wr_addr,
	input  logic [AW-1:0] rd_addr,
	output dp_status_t    sts,
	output logic          out_valid,
	input  logic          out_ready,
	output out_piece_t    out_piece
);

	typedef struct packed {
		logic [31:0] start;
		logic [32:0] stop;
		logic [31:0] tag;
	} tbl_entry_t;

	typedef struct packed {
		logic [31:0] off;
		logic [31:0] len;
		logic [31:0] tag;
		logic        ovl;
		logic        ne;
	} clip_t;

	tbl_entry_t  mem [MAX_SCRIPT_RUNS];
	tbl_entry_t  rd_s1;
	clip_t       clip_s2;
	clip_t       clip_d;
	logic [31:0] run_off_q;
	logic [31:0] run_len_q;
	logic [32:0] run_end_q;
	logic [6:0]  level_q;
	logic        ovf_q;
	logic [31:0] pend_off_q;
	logic [31:0] pend_len_q;
	logic [31:0] pend_tag_q;
	logic        pend_v_q;
	logic        any_q;
	out_piece_t  out_q;
	logic        out_v_q;
	logic        out_free;
	logic        out_load;
	logic [31:0] s_clip;
	logic [32:0] e_clip;
	logic [33:0] diff;

	always_ff @(posedge clk) begin
		if (cmd.tbl_wr) begin
			mem[wr_addr] <= '{start: in_item.run_offset,
				stop: {1'b0, in_item.run_offset} + {1'b0, in_item.run_length},
				tag: in_item.run_script};
		end
		if (cmd.rd_en) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	always_comb begin
		s_clip = (rd_s1.start < run_off_q) ? run_off_q : rd_s1.start;
		e_clip = (rd_s1.stop > run_end_q) ? run_end_q : rd_s1.stop;
		diff   = {1'b0, e_clip} - {2'b00, s_clip};
		clip_d.off = s_clip;
		clip_d.len = diff[31:0];
		clip_d.tag = rd_s1.tag;
		clip_d.ovl = (rd_s1.stop > {1'b0, run_off_q}) && ({1'b0, rd_s1.start} < run_end_q);
		clip_d.ne  = !diff[33] && (diff != '0);
	end

	always_ff @(posedge clk) begin
		if (cmd.s2_en) begin
			clip_s2 <= clip_d;
		end
		if (cmd.run_cap) begin
			run_off_q <= in_item.run_offset;
			run_len_q <= in_item.run_length;
			run_end_q <= {1'b0, in_item.run_offset} + {1'b0, in_item.run_length};
			level_q   <= in_item.run_level;
		end
		if (cmd.pend_load) begin
			pend_off_q <= clip_s2.off;
			pend_len_q <= clip_s2.len;
			pend_tag_q <= clip_s2.tag;
		end
		if (cmd.pend_out) begin
			out_q <= '{piece_offset: pend_off_q, piece_length: pend_len_q,
				piece_script: pend_tag_q, piece_level: level_q,
				last_piece: cmd.out_last, table_overflow: ovf_q};
		end else if (cmd.pass_out) begin
			out_q <= '{piece_offset: run_off_q, piece_length: run_len_q,
				piece_script: 32'd0, piece_level: level_q,
				last_piece: 1'b1, table_overflow: ovf_q};
		end
	end

	assign out_load = cmd.pend_out || cmd.pass_out;
	assign out_free = !out_v_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q    <= 1'b0;
			pend_v_q <= 1'b0;
			any_q    <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (cmd.set_ovf) begin
				ovf_q <= 1'b1;
			end
			if (cmd.scan_init) begin
				pend_v_q <= 1'b0;
				any_q    <= 1'b0;
			end else begin
				if (cmd.pend_load) begin
					pend_v_q <= 1'b1;
				end else if (cmd.pend_out) begin
					pend_v_q <= 1'b0;
				end
				if (cmd.s2_take && clip_s2.ovl) begin
					any_q <= 1'b1;
				end
			end
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign sts.s2_nonempty = clip_s2.ne;
	assign sts.pend_full   = pend_v_q;
	assign sts.out_free    = out_free;
	assign sts.any_hit     = any_q;
	assign out_valid       = out_v_q;
	assign out_piece       = out_q;

	a_pend_out_has_piece: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pend_out |-> pend_v_q)
		else $error("pending piece sent while none is held");

	a_pass_only_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pass_out |-> (!any_q && !pend_v_q))
		else $error("pass-through piece sent although a script run overlapped");

	a_no_out_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_v_q || out_ready))
		else $error("output register overwritten before transfer");

endmodule

FILE: hdl/bidi_script_run_intersect_top.sv
// Top level of the bidi script-run intersect block.
//
// The block holds a table of up to MAX_SCRIPT_RUNS script runs and cuts visual runs
// against it. Input items arrive on in_valid/in_ready with an in_item payload; the
// action field selects a table clear, a script run load or a visual run. Pieces
// leave on out_valid/out_ready with an out_piece payload, one transfer per piece.
// A clear or load gives no piece. A visual run holds the input while the block
// works on it: the table memory is read one entry per cycle, while the receiver
// keeps up, through a two-stage read and clip pipeline, then the last held piece
// (or the pass-through piece when nothing overlapped) is handed to the output
// register, and its transfer can start in the cycle in which the next input item
// is taken. At most 16 pieces leave per visual run, and the last one carries
// last_piece.
// A new item is taken only once the previous visual run has finished scanning;
// the output register lets the next item in while its final piece still waits.
// When the receiver stalls, one piece waits in the output register and one in the
// pending register, after which the scan pipeline holds in place.
// Reset empties the table, clears the sticky overflow flag and drops any piece
// in flight; table entries themselves are not cleared, as only entries below the
// stored count are ever read.
module bidi_script_run_intersect_top import bsri_pkg::*; #(
	parameter int unsigned MAX_SCRIPT_RUNS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_ready,
	output out_piece_t out_piece
);

	localparam int unsigned AW = (MAX_SCRIPT_RUNS > 1) ? $clog2(MAX_SCRIPT_RUNS) : 1;

	// Command and status between the controller and the datapath.
	ctrl_cmd_t     cmd;
	dp_status_t    sts;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] rd_addr;

	// The controller owns the stored count, scan index and piece count.
	bsri_ctrl #(
		.MAX_SCRIPT_RUNS(MAX_SCRIPT_RUNS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (in_item.action),
		.rtl      (in_item.run_level[0]),
		.sts      (sts),
		.cmd      (cmd),
		.wr_addr  (wr_addr),
		.rd_addr  (rd_addr)
	);

	// The datapath holds the table memory, clip logic and the output register.
	bsri_dp #(
		.MAX_SCRIPT_RUNS(MAX_SCRIPT_RUNS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cmd       (cmd),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_piece (out_piece)
	);

endmodule

FILE: tb/run_clip_check_pkg.sv
// Scoreboard class that predicts and checks the shaping pieces of the script-run intersect block.
package run_clip_check_pkg;

	import bsri_pkg::*;

	class run_clip_scoreboard #(int unsigned DEPTH = 16);

		logic [31:0] span_start [DEPTH];
		logic [31:0] span_len   [DEPTH];
		logic [31:0] span_tag   [DEPTH];
		int unsigned span_count;
		bit          overflow_seen;
		out_piece_t  pieces_due [$];
		int unsigned mismatches;

		function new();
			span_count    = 0;
			overflow_seen = 1'b0;
			mismatches    = 0;
		endfunction

		// Updates the table copy for one accepted input transfer and queues its pieces.
		function void note_item(in_item_t item);
			case (item.action)
				ACT_CLEAR: begin
					span_count = 0;
				end
				ACT_LOAD: begin
					if (span_count < DEPTH) begin
						span_start[span_count] = item.run_offset;
						span_len[span_count]   = item.run_length;
						span_tag[span_count]   = item.run_script;
						span_count++;
					end else begin
						overflow_seen = 1'b1;
					end
				end
				ACT_RUN: begin
					clip_visual_run(item);
				end
				default: begin
				end
			endcase
		endfunction

		// Run ends are formed in 33 bits so that nothing wraps.
		function void clip_visual_run(in_item_t item);
			logic [32:0] v_start, v_end, s, e;
			bit          hit;
			bit          rtl;
			int unsigned n, idx, k;
			out_piece_t  piece;
			v_start = {1'b0, item.run_offset};
			v_end   = v_start + item.run_length;
			hit     = 1'b0;
			for (n = 0; n < span_count; n++) begin
				s = {1'b0, span_start[n]};
				e = s + span_len[n];
				if (e > v_start && s < v_end)
					hit = 1'b1;
			end
			piece                = '0;
			piece.piece_level    = item.run_level;
			piece.table_overflow = overflow_seen;
			if (!hit) begin
				piece.piece_offset = item.run_offset;
				piece.piece_length = item.run_length;
				piece.last_piece   = 1'b1;
				pieces_due.push_back(piece);
				return;
			end
			rtl = item.run_level[0];
			k   = 0;
			for (n = 0; n < span_count && k < MAX_RESULTS; n++) begin
				idx = rtl ? span_count - 1 - n : n;
				s   = {1'b0, span_start[idx]};
				e   = s + span_len[idx];
				if (s < v_start)
					s = v_start;
				if (e > v_end)
					e = v_end;
				if (e <= s)
					continue;
				piece.piece_offset = s[31:0];
				piece.piece_length = 32'(e - s);
				piece.piece_script = span_tag[idx];
				pieces_due.push_back(piece);
				k++;
			end
			if (k > 0) begin
				piece            = pieces_due.pop_back();
				piece.last_piece = 1'b1;
				pieces_due.push_back(piece);
			end
		endfunction

		function void compare_field(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", field, want, got);
				mismatches++;
			end
		endfunction

		// Compares one accepted output transfer with the oldest queued piece.
		function void check_piece(out_piece_t got);
			out_piece_t want;
			if (pieces_due.size() == 0) begin
				$error("piece at offset %0h arrived with none outstanding", got.piece_offset);
				mismatches++;
				return;
			end
			want = pieces_due.pop_front();
			compare_field("piece_offset", want.piece_offset, got.piece_offset);
			compare_field("piece_length", want.piece_length, got.piece_length);
			compare_field("piece_script", want.piece_script, got.piece_script);
			compare_field("piece_level", 32'(want.piece_level), 32'(got.piece_level));
			compare_field("last_piece", 32'(want.last_piece), 32'(got.last_piece));
			compare_field("table_overflow", 32'(want.table_overflow),
				32'(got.table_overflow));
		endfunction

	endclass

endpackage

FILE: tb/bidi_script_run_intersect_top_tb.sv
// Self-checking testbench for the bidi script-run intersect top level.
module bidi_script_run_intersect_top_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import bsri_pkg::*;
	import run_clip_check_pkg::*;

	localparam int unsigned TABLE_DEPTH   = 16;
	localparam int unsigned ITEM_TARGET   = 320;
	// Long receiver hold-off, long enough for the output and pending registers to fill
	// and for the block to push back on its input.
	localparam int unsigned HOLD_CYCLES   = 400;
	// Settling time at the end of the run; it leaves ample room for a
	// stray piece to show up after the last expected one.
	localparam int unsigned SETTLE_CYCLES = 40;
	// The action code that the block must ignore.
	localparam logic [1:0]  ACT_UNUSED    = 2'd3;

	// Ready patterns of the receiver.
	typedef enum int unsigned {
		RX_FREE,
		RX_COIN,
		RX_SPARSE,
		RX_CADENCE
	} rx_mode_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	in_item_t   in_item;
	logic       out_valid;
	logic       out_ready;
	out_piece_t out_piece;

	run_clip_scoreboard #(TABLE_DEPTH) clip_model;

	// Sender bookkeeping. Ignored items (the unused action) do not count toward the
	// target. A steady sender offers back to back with no gaps at all.
	int unsigned items_sent    = 0;
	int unsigned burst_left    = 0;
	bit          steady_sender = 1'b0;
	bit          drained_once  = 1'b0;

	bidi_script_run_intersect_top #(
		.MAX_SCRIPT_RUNS(TABLE_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_piece(out_piece)
	);

	always #10 clk = ~clk;

	// Watchdog. The slowest correct run is about 320 items, each a full table scan
	// plus 16 pieces against a receiver that is ready one cycle in four, plus
	// sender gaps and two long hold-offs: roughly 1.2 ms in all. Eight
	// milliseconds is several times that.
	initial begin
		#8_000_000;
		$display("Mismatches found");
		$finish;
	end

	// Both handshakes are sampled at the rising edge, before any nonblocking update of
	// that edge lands, so the checks see the values that the block saw. The output is
	// checked first so that a piece can never be matched against an expectation that
	// was only queued at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				clip_model.check_piece(out_piece);
			if (in_valid && in_ready)
				clip_model.note_item(in_item);
		end
	end

	function automatic in_item_t make_item(logic [1:0] act, logic [31:0] off,
		logic [31:0] len, logic [6:0] lvl, logic [31:0] tag);
		in_item_t item;
		item.action     = act;
		item.run_offset = off;
		item.run_length = len;
		item.run_level  = lvl;
		item.run_script = tag;
		return item;
	endfunction

	// Offers one item and returns at the edge of its transfer. Between bursts the
	// sender idles for a random number of cycles; within a burst valid stays high and
	// the next payload replaces the accepted one at the same edge.
	task automatic offer(input in_item_t item);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = steady_sender ? 0 : $urandom_range(0, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 10);
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item  <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (item.action != ACT_UNUSED)
			items_sent++;
	endtask

	task automatic run_directed();
		int unsigned i;
		// With the table empty every visual run passes through whole with script 0,
		// even one of zero length.
		offer(make_item(ACT_RUN, 32'd0, 32'd0, 7'd0, 32'd0));
		// The unused action with every bit set must change nothing.
		offer(make_item(ACT_UNUSED, '1, '1, 7'h7f, '1));
		offer(make_item(ACT_LOAD, 32'd100, 32'd50, 7'd0, 32'h4c61_746e));
		offer(make_item(ACT_LOAD, 32'd140, 32'd40, 7'd0, 32'h4172_6162));
		// A zero-length script run that will lie strictly inside a later visual run.
		offer(make_item(ACT_LOAD, 32'd200, 32'd0, 7'd0, 32'h4865_6272));
		// Two overlapping clips in table order, then the same run right to left.
		offer(make_item(ACT_RUN, 32'd120, 32'd100, 7'd0, 32'd0));
		offer(make_item(ACT_RUN, 32'd120, 32'd100, 7'd1, 32'd0));
		// No stored run overlaps, so the run passes through.
		offer(make_item(ACT_RUN, 32'd300, 32'd10, 7'd2, 32'd0));
		// Only the empty script run overlaps: it blocks the pass-through piece and
		// emits nothing, so no piece at all comes out.
		offer(make_item(ACT_RUN, 32'd190, 32'd20, 7'd0, 32'd0));
		// A zero-length visual run inside a script run gives no piece either.
		offer(make_item(ACT_RUN, 32'd130, 32'd0, 7'd3, 32'd0));
		offer(make_item(ACT_CLEAR, '1, '1, 7'h7f, '1));
		// Fill the table: fifteen adjacent tiles and one entry whose end passes 2^32.
		for (i = 0; i < TABLE_DEPTH - 1; i++)
			offer(make_item(ACT_LOAD, 32'(i * 4), 32'd4, 7'd0, 32'h100 + i));
		offer(make_item(ACT_LOAD, 32'hffff_fff0, '1, 7'd0, '1));
		// One visual run across all of it gives the largest number of pieces.
		offer(make_item(ACT_RUN, 32'd0, '1, 7'd1, 32'd0));
		// A load into the full table is dropped and sets the sticky flag.
		offer(make_item(ACT_LOAD, 32'h5555_5555, 32'haaaa_aaaa, 7'h2a, 32'h5a5a_a5a5));
		offer(make_item(ACT_RUN, 32'd2, 32'd10, 7'd126, 32'd0));
	endtask

	// Mostly well-formed sequences: an optional clear, a group of script runs laid out
	// in logical order inside a window, then visual runs that land in the same window
	// so that they overlap. Now and then a burst of arbitrary items is sent instead.
	task automatic random_sequence();
		logic [31:0] base, cursor, len, off;
		int unsigned n_loads, n_runs;
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 4))
				offer(make_item(2'($urandom_range(0, 3)), $urandom, $urandom,
					7'($urandom_range(0, 127)), $urandom));
			return;
		end
		// Some windows sit at the very top of the offset range so that run ends
		// carry into the 33rd bit.
		base = ($urandom_range(0, 5) == 0) ? 32'hffff_ffc0 + $urandom_range(0, 63) : $urandom;
		if ($urandom_range(0, 3) != 0)
			offer(make_item(ACT_CLEAR, $urandom, $urandom, 7'($urandom_range(0, 127)),
				$urandom));
		n_loads = ($urandom_range(0, 11) == 0) ? TABLE_DEPTH + 2 : $urandom_range(0, 16);
		cursor  = base;
		repeat (n_loads) begin
			cursor += $urandom_range(0, 3);
			len = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 12);
			offer(make_item(ACT_LOAD, cursor, len, 7'($urandom_range(0, 127)), $urandom));
			cursor += (len > 12) ? 32'd8 : len;
		end
		n_runs = $urandom_range(1, 4);
		repeat (n_runs) begin
			off = ($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, 80);
			len = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 60);
			offer(make_item(ACT_RUN, off, len, 7'($urandom_range(0, 127)), $urandom));
		end
	endtask

	// Receiver. It switches at random between ready patterns and, at two
	// fixed points counted from the end of reset, holds off for a long stretch while
	// the sender keeps offering.
	initial begin
		int unsigned cyc;
		rx_mode_t    mode;
		cyc  = 0;
		mode = RX_FREE;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc == 1200 || cyc == 3000) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				cyc += HOLD_CYCLES;
			end
			if (cyc % 48 == 0)
				mode = rx_mode_t'($urandom_range(0, 3));
			case (mode)
				RX_FREE:    out_ready <= 1'b1;
				RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
				RX_SPARSE:  out_ready <= ($urandom_range(0, 3) == 0);
				default:    out_ready <= ((cyc % 7) < 4);
			endcase
		end
	end

	// Main sequence: reset once, directed items, then random sequences until the item
	// target is reached. Halfway through, the sender stops until every queued piece has
	// come out. At the end it waits for the queue to drain, lets the block settle, and
	// reports. Each drain first waits at a clock edge, so that the pieces of the last accepted
	// item are already queued when the queue is looked at.
	initial begin
		clip_model = new();
		in_valid <= 1'b0;
		in_item  <= '0;
		arst_n   <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		while (items_sent < ITEM_TARGET) begin
			if (!drained_once && items_sent >= ITEM_TARGET / 2) begin
				in_valid <= 1'b0;
				@(posedge clk);
				while (clip_model.pieces_due.size() != 0)
					@(posedge clk);
				drained_once = 1'b1;
			end
			steady_sender = ($urandom_range(0, 4) == 0);
			random_sequence();
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (clip_model.pieces_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (clip_model.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
